/* rtl/itseg_pkg.sv */
// ----------------------------------------------------------------------------
// itseg_pkg: shared types, constants and functions of the contour segment core
// Holds the field widths, the queue and pipeline item types, the corner sort
// and the division steps used by the front and back parts.
// ----------------------------------------------------------------------------
package itseg_pkg;

  // Field widths.
  localparam int PotW      = 16;
  localparam int CellW     = 8;
  localparam int CoordW    = 16;
  localparam int CoordExtW = CoordW + 1;
  localparam int FracW     = 8;
  localparam int CountW    = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  // Level arithmetic: index times span is below 2**24 in magnitude.
  localparam int ProdMagW        = 24;
  localparam int LevelW          = 26;
  localparam int DivBitsPerStage = 4;
  localparam int DivStages       = ProdMagW / DivBitsPerStage;

  // Edge interpolation quotient lies in 0..256.
  localparam int QuoW             = 9;
  localparam int EdgeBitsPerStage = 3;
  localparam int EdgeStages       = QuoW / EdgeBitsPerStage;

  localparam int GridSizeDefault  = 256;
  localparam int QueueDepthDefault = 4;
  localparam logic [CountW-1:0] CountReset = CountW'(10);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW   = 2'd0,
    CFG_HIGH  = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PotW-1:0] pot;
    logic                   ox;
    logic                   oy;
  } vertex_t;

  typedef vertex_t [2:0] vtx3_t;

  typedef struct packed {
    logic [PotW-1:0] num;
    logic [PotW-1:0] den;
    logic            hx;
    logic            hy;
    logic            lx;
    logic            ly;
  } edge_t;

  typedef struct packed {
    logic  hit;
    edge_t start_edge;
    edge_t end_edge;
  } tri_job_t;

  typedef struct packed {
    logic [CellW-1:0] cx;
    logic [CellW-1:0] cy;
    tri_job_t         lower;
    tri_job_t         upper;
  } cell_job_t;

  typedef struct packed {
    logic [CellW-1:0] cx;
    logic [CellW-1:0] cy;
    logic             keep;
    logic             neg;
    vtx3_t            lower;
    vtx3_t            upper;
  } front_pay_t;

  typedef struct packed {
    logic [CountW-1:0]   rem;
    logic [ProdMagW-1:0] sh;
  } lvl_div_t;

  typedef struct packed {
    logic [CellW-1:0] cx;
    logic [CellW-1:0] cy;
    logic             half;
    logic             last;
    edge_t            start_edge;
    edge_t            end_edge;
  } seg_req_t;

  typedef struct packed {
    logic [PotW:0]   rem;
    logic [QuoW-1:0] quo;
  } div_state_t;

  // Stable three-pass bubble sort; ties keep their listed order.
  function automatic vtx3_t sort3(vtx3_t v);
    vtx3_t   s;
    vertex_t t;
    s = v;
    for (int p = 0; p < 3; p++) begin
      for (int j = 0; j < 2; j++) begin
        if ($signed(s[j].pot) > $signed(s[j+1].pot)) begin
          t      = s[j];
          s[j]   = s[j+1];
          s[j+1] = t;
        end
      end
    end
    return s;
  endfunction

  // A few restoring division steps of the level quotient.
  function automatic lvl_div_t lvl_div_steps(lvl_div_t st, logic [CountW-1:0] d);
    lvl_div_t        s;
    logic [CountW:0] r;
    s = st;
    for (int i = 0; i < DivBitsPerStage; i++) begin
      r    = {s.rem, s.sh[ProdMagW-1]};
      s.sh = {s.sh[ProdMagW-2:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r       = r - {1'b0, d};
        s.sh[0] = 1'b1;
      end
      s.rem = r[CountW-1:0];
    end
    return s;
  endfunction

  // Edge from vertex lo to vertex hi, with the distance of the level below hi.
  function automatic edge_t make_edge(vertex_t hi, vertex_t lo,
                                      logic signed [LevelW-1:0] lvl);
    edge_t                    e;
    logic signed [LevelW-1:0] nh;
    logic signed [LevelW-1:0] nl;
    nh    = LevelW'($signed(hi.pot));
    nl    = LevelW'($signed(lo.pot));
    e.num = PotW'(nh - lvl);
    e.den = PotW'(nh - nl);
    e.hx  = hi.ox;
    e.hy  = hi.oy;
    e.lx  = lo.ox;
    e.ly  = lo.oy;
    return e;
  endfunction

  // Decide whether a sorted triangle holds the level and pick its edges.
  function automatic tri_job_t classify(vtx3_t s, logic signed [LevelW-1:0] lvl);
    tri_job_t                 j;
    logic signed [LevelW-1:0] n0;
    logic signed [LevelW-1:0] n1;
    logic signed [LevelW-1:0] n2;
    n0    = LevelW'($signed(s[0].pot));
    n1    = LevelW'($signed(s[1].pot));
    n2    = LevelW'($signed(s[2].pot));
    j.hit = !(lvl < n0 || lvl > n2);
    if (lvl < n1) begin
      j.start_edge = make_edge(s[1], s[0], lvl);
    end else begin
      j.start_edge = make_edge(s[2], s[1], lvl);
    end
    j.end_edge = make_edge(s[2], s[0], lvl);
    return j;
  endfunction

  // A few restoring steps of num * 256 / den, where num never exceeds den.
  function automatic div_state_t edge_div_steps(div_state_t st, logic [PotW-1:0] den);
    div_state_t s;
    logic       ge;
    s = st;
    for (int i = 0; i < EdgeBitsPerStage; i++) begin
      ge = (s.rem >= {1'b0, den});
      if (ge) begin
        s.rem = s.rem - {1'b0, den};
      end
      s.rem = {s.rem[PotW-1:0], 1'b0};
      s.quo = {s.quo[QuoW-2:0], ge};
    end
    return s;
  endfunction

  // One coordinate of a crossing: the high vertex moved by the quotient.
  function automatic logic [CoordW-1:0] coord(logic [CellW-1:0] c, logic h, logic l,
                                              logic flat, logic [QuoW-1:0] q);
    logic [CoordExtW-1:0] p;
    p = CoordExtW'({c, FracW'(0)}) + (CoordExtW'(h) << FracW);
    if (!flat && h && !l) begin
      p = p - CoordExtW'(q);
    end else if (!flat && !h && l) begin
      p = p + CoordExtW'(q);
    end
    return p[CoordW-1:0];
  endfunction

endpackage

/* rtl/itseg_queue.sv */
// ----------------------------------------------------------------------------
// itseg_queue: short first-in first-out queue between front and back
// Holds classified cells so that the front and the back can stall on their own.
// ----------------------------------------------------------------------------
module itseg_queue #(
  parameter int Width = 8,
  parameter int Depth = itseg_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] entries [Depth];
  logic [PtrW:0]    wptr;
  logic [PtrW:0]    rptr;

  // Pointers carry one extra bit to tell full from empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr[PtrW-1:0]] <= wdata;
    end
  end

  assign rdata = entries[rptr[PtrW-1:0]];
  assign empty = (wptr == rptr);
  assign full  = (wptr[PtrW] != rptr[PtrW]) && (wptr[PtrW-1:0] == rptr[PtrW-1:0]);

endmodule

/* rtl/itseg_front.sv */
// ----------------------------------------------------------------------------
// itseg_front: cell intake, level division and triangle classification
// Accepts one cell a cycle unless a full queue stalls it, forms the contour
// level in a pipelined divider, sorts both triangles and hands cells inside the
// grid with at least one crossing to the queue.
module itseg_front #(
  parameter int GridSize = itseg_pkg::GridSizeDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [itseg_pkg::PotW-1:0]   low_potential,
  input  logic signed [itseg_pkg::PotW-1:0]   high_potential,
  input  logic [itseg_pkg::CountW-1:0]        level_count,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [itseg_pkg::CellW-1:0]         cell_x,
  input  logic [itseg_pkg::CellW-1:0]         cell_y,
  input  logic [itseg_pkg::CellW-1:0]         level_index,
  input  logic signed [itseg_pkg::PotW-1:0]   pot_00,
  input  logic signed [itseg_pkg::PotW-1:0]   pot_10,
  input  logic signed [itseg_pkg::PotW-1:0]   pot_01,
  input  logic signed [itseg_pkg::PotW-1:0]   pot_11,
  input  logic                                q_full,
  output logic                                q_push,
  output itseg_pkg::cell_job_t                q_wdata
);

  localparam int MaxCellW = itseg_pkg::CellW + 1;
  localparam logic [MaxCellW-1:0] MaxCell = MaxCellW'(GridSize - 2);

  logic                                    adv;
  logic                                    in_fire;
  logic signed [itseg_pkg::PotW:0]         span;
  logic signed [itseg_pkg::CellW:0]        idx_s;
  logic signed [itseg_pkg::LevelW-1:0]     prod;
  logic [itseg_pkg::CountW-1:0]            cnt;
  itseg_pkg::front_pay_t                   pay_in;
  itseg_pkg::vtx3_t                        lower_raw;
  itseg_pkg::vtx3_t                        upper_raw;

  logic [itseg_pkg::DivStages:0]           fv;
  itseg_pkg::front_pay_t                   fpay [itseg_pkg::DivStages+1];
  itseg_pkg::lvl_div_t                     ldiv [itseg_pkg::DivStages+1];

  logic                                    lv;
  itseg_pkg::front_pay_t                   lpay;
  logic signed [itseg_pkg::LevelW-1:0]     lvl;
  logic signed [itseg_pkg::LevelW-1:0]     lvl_next;
  logic signed [itseg_pkg::LevelW-1:0]     quo_s;
  itseg_pkg::tri_job_t                     lower_job;
  itseg_pkg::tri_job_t                     upper_job;
  logic                                    want_push;

  // The whole front moves together unless its last stage waits on a full queue.
  assign adv      = !want_push || !q_full;
  assign in_stall = !adv;
  assign in_fire  = in_valid && adv;

  // Level numerator and divisor.
  assign span  = $signed({high_potential[itseg_pkg::PotW-1], high_potential})
               - $signed({low_potential[itseg_pkg::PotW-1], low_potential});
  assign idx_s = $signed({1'b0, level_index});
  assign prod  = idx_s * span;
  assign cnt   = (level_count == '0) ? itseg_pkg::CountW'(1) : level_count;

  // Triangle corners as listed, then sorted by potential.
  always_comb begin
    lower_raw[0] = '{pot: pot_00, ox: 1'b0, oy: 1'b0};
    lower_raw[1] = '{pot: pot_10, ox: 1'b1, oy: 1'b0};
    lower_raw[2] = '{pot: pot_01, ox: 1'b0, oy: 1'b1};
    upper_raw[0] = '{pot: pot_10, ox: 1'b1, oy: 1'b0};
    upper_raw[1] = '{pot: pot_11, ox: 1'b1, oy: 1'b1};
    upper_raw[2] = '{pot: pot_01, ox: 1'b0, oy: 1'b1};
    pay_in.cx    = cell_x;
    pay_in.cy    = cell_y;
    pay_in.keep  = !(({1'b0, cell_x} > MaxCell) || ({1'b0, cell_y} > MaxCell));
    pay_in.neg   = prod[itseg_pkg::LevelW-1];
    pay_in.lower = itseg_pkg::sort3(lower_raw);
    pay_in.upper = itseg_pkg::sort3(upper_raw);
  end

  // Stage valid bits, including the level stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      lv <= 1'b0;
    end else if (adv) begin
      fv <= {fv[itseg_pkg::DivStages-1:0], in_fire};
      lv <= fv[itseg_pkg::DivStages];
    end
  end

  // Intake stage: product magnitude and sorted corners.
  always_ff @(posedge clk) begin
    if (adv) begin
      fpay[0]     <= pay_in;
      ldiv[0].rem <= '0;
      ldiv[0].sh  <= prod[itseg_pkg::LevelW-1] ?
                     itseg_pkg::ProdMagW'(-prod) : itseg_pkg::ProdMagW'(prod);
    end
  end

  // Divider stages, a few quotient bits each.
  for (genvar k = 1; k <= itseg_pkg::DivStages; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        fpay[k] <= fpay[k-1];
        ldiv[k] <= itseg_pkg::lvl_div_steps(ldiv[k-1], cnt);
      end
    end
  end

  // Level stage: sign restored and offset by the configured low potential.
  assign quo_s    = $signed({2'b00, ldiv[itseg_pkg::DivStages].sh});
  assign lvl_next = itseg_pkg::LevelW'(low_potential)
                  + (fpay[itseg_pkg::DivStages].neg ? -quo_s : quo_s);

  always_ff @(posedge clk) begin
    if (adv) begin
      lpay <= fpay[itseg_pkg::DivStages];
      lvl  <= lvl_next;
    end
  end

  // Classification and queue write.
  assign lower_job = itseg_pkg::classify(lpay.lower, lvl);
  assign upper_job = itseg_pkg::classify(lpay.upper, lvl);
  assign want_push = lv && lpay.keep && (lower_job.hit || upper_job.hit);
  assign q_push    = want_push && !q_full;

  always_comb begin
    q_wdata.cx    = lpay.cx;
    q_wdata.cy    = lpay.cy;
    q_wdata.lower = lower_job;
    q_wdata.upper = upper_job;
  end

endmodule

/* rtl/itseg_back.sv */
// ----------------------------------------------------------------------------
// itseg_back: segment interpolation and result output
// Takes classified cells from the queue, issues one segment a cycle unless the
// output stalls, divides both crossings in a short pipeline and holds the result
// in an output register.
module itseg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  itseg_pkg::cell_job_t          q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itseg_pkg::CoordW-1:0]  start_x,
  output logic [itseg_pkg::CoordW-1:0]  start_y,
  output logic [itseg_pkg::CoordW-1:0]  end_x,
  output logic [itseg_pkg::CoordW-1:0]  end_y,
  output logic                          triangle_half,
  output logic                          last_segment
);

  logic                             adv;
  logic                             half_done;
  logic                             split;
  logic                             issue_upper;
  itseg_pkg::tri_job_t              pick;
  itseg_pkg::seg_req_t              req_in;

  logic [itseg_pkg::EdgeStages:0]   bv;
  itseg_pkg::seg_req_t              breq [itseg_pkg::EdgeStages+1];
  itseg_pkg::div_state_t            sdiv [itseg_pkg::EdgeStages+1];
  itseg_pkg::div_state_t            ediv [itseg_pkg::EdgeStages+1];

  itseg_pkg::seg_req_t              fin;
  logic                             flat_s;
  logic                             flat_e;

  // The back moves whenever the output register is free or being taken.
  assign adv = !out_valid || !out_stall;

  // A cell with two crossings is issued as two segments, lower triangle first.
  assign split       = q_rdata.lower.hit && !half_done && q_rdata.upper.hit;
  assign issue_upper = !(q_rdata.lower.hit && !half_done);
  assign pick        = issue_upper ? q_rdata.upper : q_rdata.lower;
  assign q_pop       = adv && !q_empty && !split;

  always_comb begin
    req_in.cx         = q_rdata.cx;
    req_in.cy         = q_rdata.cy;
    req_in.half       = issue_upper;
    req_in.last       = !split;
    req_in.start_edge = pick.start_edge;
    req_in.end_edge   = pick.end_edge;
  end

  // Control state: half-issued flag and stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_done <= 1'b0;
      bv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (!q_empty) begin
        half_done <= split;
      end
      bv        <= {bv[itseg_pkg::EdgeStages-1:0], !q_empty};
      out_valid <= bv[itseg_pkg::EdgeStages];
    end
  end

  // Issue stage: load both divisions.
  always_ff @(posedge clk) begin
    if (adv) begin
      breq[0]     <= req_in;
      sdiv[0].rem <= {1'b0, pick.start_edge.num};
      sdiv[0].quo <= '0;
      ediv[0].rem <= {1'b0, pick.end_edge.num};
      ediv[0].quo <= '0;
    end
  end

  // Division stages for the start and end crossings side by side.
  for (genvar k = 1; k <= itseg_pkg::EdgeStages; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        breq[k] <= breq[k-1];
        sdiv[k] <= itseg_pkg::edge_div_steps(sdiv[k-1], breq[k-1].start_edge.den);
        ediv[k] <= itseg_pkg::edge_div_steps(ediv[k-1], breq[k-1].end_edge.den);
      end
    end
  end

  // A flat edge gives the higher vertex itself.
  assign fin    = breq[itseg_pkg::EdgeStages];
  assign flat_s = (fin.start_edge.den == '0);
  assign flat_e = (fin.end_edge.den == '0);

  // Output register: coordinates from the quotients.
  always_ff @(posedge clk) begin
    if (adv) begin
      start_x       <= itseg_pkg::coord(fin.cx, fin.start_edge.hx, fin.start_edge.lx, flat_s,
                                        sdiv[itseg_pkg::EdgeStages].quo);
      start_y       <= itseg_pkg::coord(fin.cy, fin.start_edge.hy, fin.start_edge.ly, flat_s,
                                        sdiv[itseg_pkg::EdgeStages].quo);
      end_x         <= itseg_pkg::coord(fin.cx, fin.end_edge.hx, fin.end_edge.lx, flat_e,
                                        ediv[itseg_pkg::EdgeStages].quo);
      end_y         <= itseg_pkg::coord(fin.cy, fin.end_edge.hy, fin.end_edge.ly, flat_e,
                                        ediv[itseg_pkg::EdgeStages].quo);
      triangle_half <= fin.half;
      last_segment  <= fin.last;
    end
  end

endmodule

/* rtl/isoline_triangle_segments_core.sv */
// ----------------------------------------------------------------------------
// isoline_triangle_segments_core: contour segments of one grid cell
// Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// The core accepts one grid cell per clock unless in_stall holds it off, and
// returns zero, one or two line segments for it, lower-left triangle first,
// with last_segment on the final one. Results leave at one segment per clock
// while out_stall is low; a cell whose two triangles both cross the level sends
// two segments through the single result channel. The front pipeline (intake,
// six divider stages for the level, one level stage) feeds a queue of four
// entries by default; the back issues a segment per cycle, unless the output
// stalls, into three interpolation division stages and an output register.
// Cells with no crossing, or outside the grid, leave no result. Configuration
// must only be written while no cell is in flight.
module isoline_triangle_segments_core #(
  parameter int GridSize   = itseg_pkg::GridSizeDefault,
  parameter int QueueDepth = itseg_pkg::QueueDepthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [itseg_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [itseg_pkg::CfgDataW-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [itseg_pkg::CellW-1:0]         cell_x,
  input  logic [itseg_pkg::CellW-1:0]         cell_y,
  input  logic [itseg_pkg::CellW-1:0]         level_index,
  input  logic signed [itseg_pkg::PotW-1:0]   pot_00,
  input  logic signed [itseg_pkg::PotW-1:0]   pot_10,
  input  logic signed [itseg_pkg::PotW-1:0]   pot_01,
  input  logic signed [itseg_pkg::PotW-1:0]   pot_11,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [itseg_pkg::CoordW-1:0]        start_x,
  output logic [itseg_pkg::CoordW-1:0]        start_y,
  output logic [itseg_pkg::CoordW-1:0]        end_x,
  output logic [itseg_pkg::CoordW-1:0]        end_y,
  output logic                                triangle_half,
  output logic                                last_segment
);

  logic signed [itseg_pkg::PotW-1:0]  low_potential;
  logic signed [itseg_pkg::PotW-1:0]  high_potential;
  logic [itseg_pkg::CountW-1:0]       level_count;

  logic                               q_push;
  logic                               q_pop;
  logic                               q_full;
  logic                               q_empty;
  itseg_pkg::cell_job_t               q_wdata;
  itseg_pkg::cell_job_t               q_rdata;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_potential  <= '0;
      high_potential <= '0;
      level_count    <= itseg_pkg::CountReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        itseg_pkg::CFG_LOW:   low_potential  <= $signed(cfg_data);
        itseg_pkg::CFG_HIGH:  high_potential <= $signed(cfg_data);
        itseg_pkg::CFG_COUNT: level_count    <= cfg_data[itseg_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  itseg_front #(
    .GridSize (GridSize)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .low_potential  (low_potential),
    .high_potential (high_potential),
    .level_count    (level_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cell_x         (cell_x),
    .cell_y         (cell_y),
    .level_index    (level_index),
    .pot_00         (pot_00),
    .pot_10         (pot_10),
    .pot_01         (pot_01),
    .pot_11         (pot_11),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  itseg_queue #(
    .Width ($bits(itseg_pkg::cell_job_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  itseg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .triangle_half (triangle_half),
    .last_segment  (last_segment)
  );

endmodule

/* rtl/itseg_check.sv */
// ----------------------------------------------------------------------------
// itseg_check: port-level checks of the contour segment core
// Watches results for stall hold, reset and order of the triangles of a cell.
// ----------------------------------------------------------------------------
module itseg_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [itseg_pkg::CoordW-1:0]  start_x,
  input logic                          triangle_half,
  input logic                          last_segment
);

  logic expect_upper;

  // Set after a lower segment that was not the last of its cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_upper <= 1'b0;
    end else if (out_valid && !out_stall) begin
      expect_upper <= !last_segment;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(start_x) && $stable(last_segment))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  a_lower_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_segment |-> !triangle_half)
    else $error("upper segment not marked last");

  a_upper_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && expect_upper |-> triangle_half && last_segment)
    else $error("second segment of a cell is not the upper one");

endmodule

bind isoline_triangle_segments_core itseg_check u_check (.*);

/* sim/tb_isoline_triangle_segments_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_isoline_triangle_segments_core: self-checking bench for the contour core
// Drives grid cells through the valid/stall handshake and predicts the
// segments of each cell in a scoreboard. Every segment that leaves the core is
// compared field by field. The run covers several register settings and
// several idling patterns, and includes one long output hold-off.
// ----------------------------------------------------------------------------

typedef struct {
  logic [7:0]         cx;
  logic [7:0]         cy;
  logic [7:0]         idx;
  logic signed [15:0] p00;
  logic signed [15:0] p10;
  logic signed [15:0] p01;
  logic signed [15:0] p11;
} cell_item_t;

typedef struct {
  logic [15:0] sx;
  logic [15:0] sy;
  logic [15:0] ex;
  logic [15:0] ey;
  logic        half;
  logic        last;
} segment_t;

// Contour segment predictor and the queue of segments still owed by the core.
class segment_scoreboard;
  longint     low_pot = 0;
  longint     high_pot = 0;
  longint     lvl_count = 10;
  segment_t   owed[$];
  int         errors = 0;
  int         cells = 0;
  int         segments = 0;

  function void set_reg(itseg_pkg::cfg_reg_e idx, logic [15:0] val);
    case (idx)
      itseg_pkg::CFG_LOW:   low_pot = longint'($signed(val));
      itseg_pkg::CFG_HIGH:  high_pot = longint'($signed(val));
      itseg_pkg::CFG_COUNT: lvl_count = longint'(val[7:0]);
      default: ;
    endcase
  endfunction

  function longint level_for(logic [7:0] idx);
    longint cnt;
    cnt = (lvl_count == 0) ? 1 : lvl_count;
    return low_pot + (longint'(idx) * (high_pot - low_pot)) / cnt;
  endfunction

  // Crossing of the level on the edge from lo to hi; a flat edge gives hi.
  function longint crossing(longint p_hi, longint p_lo, longint n_hi, longint n_lo,
                            longint lvl);
    if (n_hi == n_lo) return p_hi;
    return p_hi - ((n_hi - lvl) * (p_hi - p_lo)) / (n_hi - n_lo);
  endfunction

  function logic [15:0] clamp_coord(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Work out the segments of one accepted cell and queue them.
  function void note_cell(cell_item_t c);
    longint   lvl, x0, y0, x1, y1, t, sx, sy, ex, ey;
    longint   n[3], px[3], py[3];
    segment_t s;
    int       produced;
    cells++;
    produced = 0;
    if (c.cx > 8'd254 || c.cy > 8'd254) return;
    lvl = level_for(c.idx);
    x0 = longint'(c.cx) * 256;
    y0 = longint'(c.cy) * 256;
    x1 = x0 + 256;
    y1 = y0 + 256;
    for (int k = 0; k < 2; k++) begin
      if (k == 0) begin
        n[0] = c.p00; px[0] = x0; py[0] = y0;
        n[1] = c.p10; px[1] = x1; py[1] = y0;
        n[2] = c.p01; px[2] = x0; py[2] = y1;
      end else begin
        n[0] = c.p10; px[0] = x1; py[0] = y0;
        n[1] = c.p11; px[1] = x1; py[1] = y1;
        n[2] = c.p01; px[2] = x0; py[2] = y1;
      end
      // Stable sort: ties keep their listed order.
      for (int p = 0; p < 3; p++) begin
        for (int j = 0; j < 2; j++) begin
          if (n[j] > n[j+1]) begin
            t = n[j];  n[j] = n[j+1];  n[j+1] = t;
            t = px[j]; px[j] = px[j+1]; px[j+1] = t;
            t = py[j]; py[j] = py[j+1]; py[j+1] = t;
          end
        end
      end
      if (lvl < n[0] || lvl > n[2]) continue;
      if (lvl < n[1]) begin
        sx = crossing(px[1], px[0], n[1], n[0], lvl);
        sy = crossing(py[1], py[0], n[1], n[0], lvl);
      end else begin
        sx = crossing(px[2], px[1], n[2], n[1], lvl);
        sy = crossing(py[2], py[1], n[2], n[1], lvl);
      end
      ex = crossing(px[2], px[0], n[2], n[0], lvl);
      ey = crossing(py[2], py[0], n[2], n[0], lvl);
      s.sx = clamp_coord(sx);
      s.sy = clamp_coord(sy);
      s.ex = clamp_coord(ex);
      s.ey = clamp_coord(ey);
      s.half = (k == 1);
      s.last = 1'b0;
      owed.push_back(s);
      produced++;
    end
    if (produced > 0) owed[owed.size()-1].last = 1'b1;
  endfunction

  function void check_segment(segment_t got);
    segment_t e;
    segments++;
    if (owed.size() == 0) begin
      $error("segment with none expected: start (%0d,%0d)", got.sx, got.sy);
      errors++;
      return;
    end
    e = owed.pop_front();
    if (got.sx !== e.sx) begin
      $error("start_x expected %0d got %0d", e.sx, got.sx); errors++;
    end
    if (got.sy !== e.sy) begin
      $error("start_y expected %0d got %0d", e.sy, got.sy); errors++;
    end
    if (got.ex !== e.ex) begin
      $error("end_x expected %0d got %0d", e.ex, got.ex); errors++;
    end
    if (got.ey !== e.ey) begin
      $error("end_y expected %0d got %0d", e.ey, got.ey); errors++;
    end
    if (got.half !== e.half) begin
      $error("triangle_half expected %0d got %0d", e.half, got.half); errors++;
    end
    if (got.last !== e.last) begin
      $error("last_segment expected %0d got %0d", e.last, got.last); errors++;
    end
  endfunction
endclass

module tb_isoline_triangle_segments_core;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         cell_x = '0;
  logic [7:0]         cell_y = '0;
  logic [7:0]         level_index = '0;
  logic signed [15:0] pot_00 = '0;
  logic signed [15:0] pot_10 = '0;
  logic signed [15:0] pot_01 = '0;
  logic signed [15:0] pot_11 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        start_x;
  logic [15:0]        start_y;
  logic [15:0]        end_x;
  logic [15:0]        end_y;
  logic               triangle_half;
  logic               last_segment;

  segment_scoreboard sb = new();
  int                send_pct = 0;
  int                recv_pct = 0;
  int                hold_left = 0;
  int                configs = 0;

  isoline_triangle_segments_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .level_index   (level_index),
    .pot_00        (pot_00),
    .pot_10        (pot_10),
    .pot_01        (pot_01),
    .pot_11        (pot_11),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .triangle_half (triangle_half),
    .last_segment  (last_segment)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: a long hold-off when one is requested, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Segment monitor.
  always @(posedge clk) begin
    segment_t got;
    if (!rst && out_valid && !out_stall) begin
      got.sx = start_x;
      got.sy = start_y;
      got.ex = end_x;
      got.ey = end_y;
      got.half = triangle_half;
      got.last = last_segment;
      sb.check_segment(got);
    end
  end

  // Offer one cell, with random idle cycles first, and wait for acceptance.
  task automatic send_cell(cell_item_t c);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cell_x      <= c.cx;
    cell_y      <= c.cy;
    level_index <= c.idx;
    pot_00      <= c.p00;
    pot_10      <= c.p10;
    pot_01      <= c.p01;
    pot_11      <= c.p11;
    do @(posedge clk); while (in_stall);
    sb.note_cell(c);
  endtask

  // Wait until the scoreboard owes no segment, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // One register write; the caller releases the write enable afterwards.
  task automatic write_reg(itseg_pkg::cfg_reg_e idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_field(logic [15:0] lo, logic [15:0] hi, logic [7:0] cnt);
    drain();
    write_reg(itseg_pkg::CFG_LOW, lo);
    write_reg(itseg_pkg::CFG_HIGH, hi);
    // The upper byte of the count write is ignored by the core.
    write_reg(itseg_pkg::CFG_COUNT, {8'($urandom), cnt});
    cfg_write <= 1'b0;
    configs++;
  endtask

  function automatic logic signed [15:0] near_level(longint lvl, int spread);
    longint v;
    v = lvl + longint'($urandom_range(2 * spread)) - spread;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  // Mostly cells whose corners straddle the level, the rest fully random.
  function automatic cell_item_t random_cell();
    cell_item_t c;
    longint     lvl;
    int         spread;
    c.cx = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom);
    c.cy = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom);
    if ($urandom_range(9) == 0 || sb.lvl_count < 2) c.idx = 8'($urandom);
    else c.idx = 8'($urandom_range(sb.lvl_count - 1, 1));
    if ($urandom_range(99) < 75) begin
      lvl = sb.level_for(c.idx);
      case ($urandom_range(2))
        0: spread = 4;
        1: spread = 400;
        default: spread = 30000;
      endcase
      c.p00 = near_level(lvl, spread);
      c.p10 = near_level(lvl, spread);
      c.p01 = near_level(lvl, spread);
      c.p11 = near_level(lvl, spread);
      if ($urandom_range(9) == 0) c.p11 = c.p00;
      if ($urandom_range(9) == 0) c.p01 = c.p10;
    end else begin
      c.p00 = 16'($urandom);
      c.p10 = 16'($urandom);
      c.p01 = 16'($urandom);
      c.p11 = 16'($urandom);
    end
    return c;
  endfunction

  function automatic cell_item_t mk(logic [7:0] x, logic [7:0] y, logic [7:0] i,
                                    logic [15:0] a, logic [15:0] b,
                                    logic [15:0] d, logic [15:0] e);
    cell_item_t c;
    c.cx = x; c.cy = y; c.idx = i;
    c.p00 = a; c.p10 = b; c.p01 = d; c.p11 = e;
    return c;
  endfunction

  initial begin
    cell_item_t c;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cells under the reset settings (level is zero).
    send_cell(mk(8'd0, 8'd0, 8'd1, 16'hFF00, 16'h0100, 16'h0100, 16'h0200));
    send_cell(mk(8'd254, 8'd254, 8'd5, 16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF));
    send_cell(mk(8'd255, 8'd3, 8'd1, 16'hFF00, 16'h0100, 16'h0100, 16'h0100));
    send_cell(mk(8'd3, 8'd255, 8'd1, 16'hFF00, 16'h0100, 16'h0100, 16'h0100));
    // Flat triangle sitting exactly on the level.
    send_cell(mk(8'd10, 8'd20, 8'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Level equal to the middle corner, and ties among corners.
    send_cell(mk(8'd7, 8'd9, 8'd2, 16'hFFF0, 16'h0000, 16'h0010, 16'h0000));
    send_cell(mk(8'd7, 8'd9, 8'd2, 16'h0010, 16'h0010, 16'hFFF0, 16'hFFF0));
    // Whole cell above, then below the level: no segment. Then full-range cells.
    send_cell(mk(8'd1, 8'd1, 8'd1, 16'h0001, 16'h0002, 16'h7FFF, 16'h0003));
    send_cell(mk(8'd1, 8'd1, 8'd1, 16'hFFFF, 16'h8000, 16'hFFFE, 16'hFFFD));
    send_cell(mk(8'd128, 8'd64, 8'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
    send_cell(mk(8'd128, 8'd64, 8'd255, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));

    // Full range, finest levels, with extreme level indexes.
    set_field(16'h8000, 16'h7FFF, 8'd255);
    send_cell(mk(8'd0, 8'd254, 8'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
    send_cell(mk(8'd254, 8'd0, 8'd255, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_cell(mk(8'd17, 8'd33, 8'd128, 16'h8000, 16'h7FFF, 16'h0000, 16'hFF80));
    send_cell(mk(8'd17, 8'd33, 8'd254, 16'h7F00, 16'h7FFF, 16'h7F80, 16'h7FC0));

    // Pressure: hold the output while cells that cross keep arriving.
    hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      c = random_cell();
      c.cx = 8'(i); c.cy = 8'(i);
      c.p00 = 16'h8000; c.p10 = 16'h7FFF; c.p01 = 16'h0000; c.p11 = 16'h8000;
      send_cell(c);
    end

    // Random phases, each under its own settings and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin set_field(16'hFC18, 16'h1388, 8'd1);   send_pct = 0;  recv_pct = 0;  end
        1: begin set_field(16'h7FFF, 16'h8000, 8'd0);   send_pct = 56; recv_pct = 0;  end
        2: begin set_field(16'hF000, 16'h0800, 8'd10);  send_pct = 0;  recv_pct = 56; end
        default: begin
          set_field(16'h8000, 16'h7FFF, 8'd255);      send_pct = 33; recv_pct = 33;
        end
      endcase
      for (int i = 0; i < 290; i++) send_cell(random_cell());
    end

    send_pct = 0;
    recv_pct = 0;
    drain();
    $display("Run covered %0d cells and %0d segments over %0d register settings,",
             sb.cells, sb.segments, configs + 1);
    $display("with idle and stall patterns on both sides and one long output hold.");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/itseg_pkg.sv
rtl/itseg_queue.sv
rtl/itseg_front.sv
rtl/itseg_back.sv
rtl/isoline_triangle_segments_core.sv
rtl/itseg_check.sv
sim/tb_isoline_triangle_segments_core.sv
